@@ hdl/clws_pkg.sv @@
package clws_pkg;

    // colour and frame geometry
    localparam int COLOR_BITS   = 32;
    localparam int MAX_WIDTH    = 1024;
    localparam int HEIGHT_LIMIT = 4096;
    localparam int COL_BITS     = $clog2(MAX_WIDTH);
    localparam int WIDTH_BITS   = 11;
    localparam int HEIGHT_BITS  = 13;

    // configuration port
    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 32;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_BACKGROUND = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_WIDTH      = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_HEIGHT     = 2'd2;

    localparam logic [WIDTH_BITS-1:0]  WIDTH_RESET  = 11'd640;
    localparam logic [HEIGHT_BITS-1:0] HEIGHT_RESET = 13'd480;

    typedef logic [COLOR_BITS-1:0] color_t;

    // which sides of the window fall outside the frame
    typedef struct packed {
        logic no_left;
        logic no_right;
        logic no_top;
        logic no_bottom;
    } edge_t;

endpackage

@@ hdl/clws_if.sv @@
interface clws_pixel_if;
    import clws_pkg::*;

    logic   valid;
    logic   ready;
    color_t pixel_color;
    logic   is_padding;

    modport source (output valid, output pixel_color, output is_padding, input ready);
    modport sink   (input valid, input pixel_color, input is_padding, output ready);
endinterface

interface clws_result_if;
    import clws_pkg::*;

    logic   valid;
    logic   ready;
    color_t next_color;
    logic   frame_last;

    modport source (output valid, output next_color, output frame_last, input ready);
    modport sink   (input valid, input next_color, input frame_last, output ready);
endinterface

@@ hdl/colored_life_window_step.sv @@
// One Life generation over a coloured raster frame, one word per cycle unless the skid
// is full. Any colour other than the background counts as alive; a live result takes
// the colour of the first live neighbour (left column top to bottom, middle, then
// right). Results trail the input by frame_width + 1 words, so after the frame the
// source sends frame_width + 1 padding words to drain it. Words pass from the read
// stage to the output or skid register; the two line stores, read and written once
// per word on separate read and write ports, set the rate. Line stores are not cleared
// after reset. Configuration must be written only while the block is idle (unchecked).
module colored_life_window_step (
    input  logic                                clk,
    input  logic                                rst_n,
    clws_pixel_if.sink                          pixels,
    clws_result_if.source                       results,
    input  logic                                cfg_write_en,
    input  logic [clws_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [clws_pkg::CFG_DATA_BITS-1:0]  cfg_data
);
    import clws_pkg::*;

    // configuration registers
    color_t                 bg_reg;
    logic [WIDTH_BITS-1:0]  width_reg;
    logic [HEIGHT_BITS-1:0] height_reg;

    // position counters
    logic [COL_BITS-1:0]    col_reg, col_next;
    logic [HEIGHT_BITS-1:0] row_reg, row_next;

    // line stores and their read words
    color_t store_upper [0:MAX_WIDTH-1];
    color_t store_middle [0:MAX_WIDTH-1];
    color_t rd_up_reg, rd_mid_reg;

    // read stage
    logic                s1_valid_reg;
    logic [COL_BITS-1:0] s1_addr_reg;
    color_t              s1_pix_reg;
    logic                s1_fwd_reg;
    logic                s1_emit_reg;
    logic                s1_last_reg;
    edge_t               s1_edges_reg;

    // last values written back, for a read that hits the same entry
    color_t last_pix_reg, last_mid_reg;

    // output register and skid
    logic   out_valid_reg, skid_valid_reg;
    color_t out_color_reg, skid_color_reg;
    logic   out_last_reg, skid_last_reg;

    logic [WIDTH_BITS-1:0]  w;
    logic [HEIGHT_BITS-1:0] h;
    logic [COL_BITS-1:0]    c;
    logic [HEIGHT_BITS-1:0] pr;
    logic                   c_zero, c_last, has_k, in_frame, last, restart;
    color_t                 pix;
    edge_t                  edges;
    logic                   accept, s1_fire, push, pop;
    color_t                 up_eff, mid_eff, rule_color;

    assign pixels.ready = !s1_valid_reg || !skid_valid_reg;
    assign accept       = pixels.valid && pixels.ready;
    assign s1_fire      = s1_valid_reg && !skid_valid_reg;
    assign push         = s1_fire && s1_emit_reg;
    assign pop          = out_valid_reg && results.ready;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bg_reg     <= '0;
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
        end
        else if (cfg_write_en)
        begin
            unique case (cfg_index)
                CFG_BACKGROUND: bg_reg     <= cfg_data[COLOR_BITS-1:0];
                CFG_WIDTH:      width_reg  <= cfg_data[WIDTH_BITS-1:0];
                CFG_HEIGHT:     height_reg <= cfg_data[HEIGHT_BITS-1:0];
                default:        ;
            endcase
        end
    end

    // frame size, saturated to the supported range
    always_comb
    begin
        w = width_reg;
        if (width_reg < WIDTH_BITS'(3))
        begin
            w = WIDTH_BITS'(3);
        end
        else if (width_reg > WIDTH_BITS'(MAX_WIDTH))
        begin
            w = WIDTH_BITS'(MAX_WIDTH);
        end
        h = height_reg;
        if (height_reg < HEIGHT_BITS'(3))
        begin
            h = HEIGHT_BITS'(3);
        end
        else if (height_reg > HEIGHT_BITS'(HEIGHT_LIMIT))
        begin
            h = HEIGHT_BITS'(HEIGHT_LIMIT);
        end
    end

    // position of the incoming word and of the delayed centre
    always_comb
    begin
        c        = ({1'b0, col_reg} >= w) ? '0 : col_reg;
        c_zero   = c == '0;
        c_last   = {1'b0, c} == (w - WIDTH_BITS'(1));
        has_k    = !(row_reg == '0 || (row_reg == HEIGHT_BITS'(1) && c_zero));
        pr       = row_reg - HEIGHT_BITS'(1) - {{(HEIGHT_BITS-1){1'b0}}, c_zero};
        in_frame = pr < h;
        last     = in_frame && c_zero && pr == (h - HEIGHT_BITS'(1));
        restart  = has_k && (!in_frame || last);

        edges.no_left   = c == COL_BITS'(1);
        edges.no_right  = c_zero;
        edges.no_top    = pr == '0;
        edges.no_bottom = pr == (h - HEIGHT_BITS'(1));

        pix = pixels.is_padding ? bg_reg : pixels.pixel_color;

        if (restart)
        begin
            col_next = '0;
            row_next = '0;
        end
        else if (c_last)
        begin
            col_next = '0;
            row_next = row_reg + HEIGHT_BITS'(1);
        end
        else
        begin
            col_next = c + COL_BITS'(1);
            row_next = row_reg;
        end
    end

    // counters and read stage control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg      <= '0;
            row_reg      <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                col_reg <= col_next;
                row_reg <= row_next;
            end
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_fire)
            begin
                s1_valid_reg <= 1'b0;
            end
        end
    end

    // read stage payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_addr_reg  <= c;
            s1_pix_reg   <= pix;
            s1_fwd_reg   <= s1_valid_reg && s1_addr_reg == c;
            s1_emit_reg  <= has_k && in_frame;
            s1_last_reg  <= last;
            s1_edges_reg <= edges;
        end
        if (s1_fire)
        begin
            last_pix_reg <= s1_pix_reg;
            last_mid_reg <= mid_eff;
        end
    end

    // column words, forwarded when the previous word wrote the same entry
    assign up_eff  = s1_fwd_reg ? last_mid_reg : rd_up_reg;
    assign mid_eff = s1_fwd_reg ? last_pix_reg : rd_mid_reg;

    // line stores: read on accept, write back as the word leaves the read stage
    always_ff @(posedge clk)
    begin
        if (s1_fire)
        begin
            store_upper[s1_addr_reg]  <= mid_eff;
            store_middle[s1_addr_reg] <= s1_pix_reg;
        end
        if (accept)
        begin
            rd_up_reg  <= store_upper[c];
            rd_mid_reg <= store_middle[c];
        end
    end

    clws_window u_window (
        .clk        (clk),
        .shift_en   (s1_fire),
        .col_up     (up_eff),
        .col_mid    (mid_eff),
        .col_new    (s1_pix_reg),
        .bg         (bg_reg),
        .edges      (s1_edges_reg),
        .next_color (rule_color)
    );

    // output register with skid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop && skid_valid_reg)
            begin
                skid_valid_reg <= 1'b0;
            end
            else if (pop && !push)
            begin
                out_valid_reg <= 1'b0;
            end
            else if (push && out_valid_reg && !pop)
            begin
                skid_valid_reg <= 1'b1;
            end
            else if (push)
            begin
                out_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop && skid_valid_reg)
        begin
            out_color_reg <= skid_color_reg;
            out_last_reg  <= skid_last_reg;
        end
        else if (push && (!out_valid_reg || pop))
        begin
            out_color_reg <= rule_color;
            out_last_reg  <= s1_last_reg;
        end
        if (push && out_valid_reg && !pop)
        begin
            skid_color_reg <= rule_color;
            skid_last_reg  <= s1_last_reg;
        end
    end

    assign results.valid      = out_valid_reg;
    assign results.next_color = out_color_reg;
    assign results.frame_last = out_last_reg;

endmodule

@@ hdl/clws_window.sv @@
module clws_window (
    input  logic            clk,
    input  logic            shift_en,
    input  clws_pkg::color_t col_up,
    input  clws_pkg::color_t col_mid,
    input  clws_pkg::color_t col_new,
    input  clws_pkg::color_t bg,
    input  clws_pkg::edge_t  edges,
    output clws_pkg::color_t next_color
);
    import clws_pkg::*;

    // middle and right columns as they stand before the shift
    color_t win_reg [0:5];
    color_t win_cell [0:8];
    logic [7:0] live;
    logic [3:0] live_count;
    color_t first_live;
    logic center_alive;
    logic masked;
    int n;

    // window after the shift, index column * 3 + row
    always_comb
    begin
        for (int i = 0; i < 6; i++)
        begin
            win_cell[i] = win_reg[i];
        end
        win_cell[6] = col_up;
        win_cell[7] = col_mid;
        win_cell[8] = col_new;
    end

    // live neighbours in scan order, cells outside the frame masked
    always_comb
    begin
        n = 0;
        live = '0;
        for (int col = 0; col < 3; col++)
        begin
            for (int row = 0; row < 3; row++)
            begin
                masked = (col == 0 && edges.no_left) || (col == 2 && edges.no_right) ||
                         (row == 0 && edges.no_top) || (row == 2 && edges.no_bottom);
                if (!(col == 1 && row == 1))
                begin
                    live[n[2:0]] = !masked && (win_cell[col * 3 + row] != bg);
                    n = n + 1;
                end
            end
        end
    end

    // neighbour count and first live colour
    always_comb
    begin
        live_count = '0;
        first_live = bg;
        for (int i = 0; i < 8; i++)
        begin
            live_count = live_count + {3'b000, live[i]};
        end
        for (int i = 7; i >= 0; i--)
        begin
            if (live[i])
            begin
                first_live = (i < 4) ? win_cell[(i < 4) ? i : 0]
                                     : win_cell[(i < 4) ? 0 : i + 1];
            end
        end
    end

    // life rule
    always_comb
    begin
        center_alive = win_cell[4] != bg;
        if (live_count <= 4'd1 || live_count >= 4'd4)
        begin
            next_color = bg;
        end
        else if (live_count == 4'd2 && !center_alive)
        begin
            next_color = bg;
        end
        else
        begin
            next_color = first_live;
        end
    end

    // window shift
    always_ff @(posedge clk)
    begin
        if (shift_en)
        begin
            win_reg[0] <= win_reg[3];
            win_reg[1] <= win_reg[4];
            win_reg[2] <= win_reg[5];
            win_reg[3] <= col_up;
            win_reg[4] <= col_mid;
            win_reg[5] <= col_new;
        end
    end

endmodule
